### hdl/icp_pkg.sv
// ----------------------------------------------------------------------------
// icp_pkg
// shared widths and the lane record that moves down the root-extraction chain
// ----------------------------------------------------------------------------
package icp_pkg;

   localparam int VALUE_W   = 32;              // input word
   localparam int REM_W     = 32;              // remainder of either root
   localparam int SQ_ROOT_W = VALUE_W / 2;     // floor sqrt of 32 bits
   localparam int CB_ROOT_W = 11;              // floor cbrt of 32 bits
   localparam int CB_SQ_W   = 2 * CB_ROOT_W;   // running square of the cube root
   localparam int SQ_DW     = REM_W + 2;       // trial subtrahend, square root
   localparam int CB_DW     = REM_W + 4;       // trial subtrahend, cube root
   localparam int NUM_CELLS = SQ_ROOT_W;       // one cell per square-root bit

   typedef struct packed {
      logic                 neg;
      logic                 zero;
      logic                 even;
      logic [REM_W-1:0]     sq_rem;
      logic [SQ_ROOT_W-1:0] sq_root;
      logic [REM_W-1:0]     cb_rem;
      logic [CB_ROOT_W-1:0] cb_root;
      logic [CB_SQ_W-1:0]   cb_root_sq;
   } icp_lane_type;

endpackage

### hdl/icp_cell.sv
// ----------------------------------------------------------------------------
// icp_cell
// one bit of square root and, for bits below the cube root's width, one bit of cube root, registered, with handshake
// ----------------------------------------------------------------------------
module icp_cell #(
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  icp_pkg::icp_lane_type in_lane,
   output logic                 up_ready,
   input  logic                 down_ready,
   output logic                 out_valid,
   output icp_pkg::icp_lane_type out_lane
);
   import icp_pkg::*;

   localparam bit CUBE_ON = (BIT < CB_ROOT_W);

   logic               valid_ff, valid_in;
   icp_lane_type       lane_ff, lane_in;
   logic [SQ_DW-1:0]   sq_delta;
   logic [CB_DW-1:0]   cb_delta;
   logic [CB_DW-1:0]   cb_y2x3;
   logic [CB_DW-1:0]   cb_yx3;
   logic [CB_SQ_W-1:0] cb_sq_next;

   assign up_ready  = !valid_ff || down_ready;
   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   always_comb begin
      lane_in = in_lane;

      // (r + 2^b)^2 - r^2
      sq_delta = ({{(SQ_DW-SQ_ROOT_W){1'b0}}, in_lane.sq_root} << (BIT + 1))
               + (SQ_DW'(1) << (2 * BIT));
      if (sq_delta <= {{(SQ_DW-REM_W){1'b0}}, in_lane.sq_rem}) begin
         lane_in.sq_rem  = in_lane.sq_rem - sq_delta[REM_W-1:0];
         lane_in.sq_root = in_lane.sq_root | (SQ_ROOT_W'(1) << BIT);
      end

      // (y + 2^b)^3 - y^3 = 3 y^2 2^b + 3 y 2^2b + 2^3b
      cb_y2x3 = ({{(CB_DW-CB_SQ_W){1'b0}}, in_lane.cb_root_sq} << 1)
              + {{(CB_DW-CB_SQ_W){1'b0}}, in_lane.cb_root_sq};
      cb_yx3  = ({{(CB_DW-CB_ROOT_W){1'b0}}, in_lane.cb_root} << 1)
              + {{(CB_DW-CB_ROOT_W){1'b0}}, in_lane.cb_root};
      cb_delta = (cb_y2x3 << BIT) + (cb_yx3 << (2 * BIT)) + (CB_DW'(1) << (3 * BIT));
      // (y + 2^b)^2 = y^2 + y 2^(b+1) + 2^2b
      cb_sq_next = in_lane.cb_root_sq
                 + CB_SQ_W'({{(CB_SQ_W-CB_ROOT_W){1'b0}}, in_lane.cb_root} << (BIT + 1))
                 + CB_SQ_W'(CB_DW'(1) << (2 * BIT));
      if (CUBE_ON) begin
         if (cb_delta <= {{(CB_DW-REM_W){1'b0}}, in_lane.cb_rem}) begin
            lane_in.cb_rem     = in_lane.cb_rem - cb_delta[REM_W-1:0];
            lane_in.cb_root    = in_lane.cb_root | CB_ROOT_W'(CB_DW'(1) << BIT);
            lane_in.cb_root_sq = cb_sq_next;
         end
      end
   end

   assign valid_in = up_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready) begin
         lane_ff <= lane_in;
      end
   end

endmodule

### hdl/integer_power_classifier.sv
// ----------------------------------------------------------------------------
// integer_power_classifier
// sign, parity, perfect-square and perfect-cube flags of a 32-bit integer
// ----------------------------------------------------------------------------
// an accepted req beat reaches its rsp beat through every cell's register in turn
// throughput: one beat per cycle while rsp_stall is low; each cell holds one beat and passes it on
// stalls ripple back only through full cells, so bubbles get squeezed out
// reset: synchronous, clears only the per-cell valid flags
module integer_power_classifier (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [icp_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_positive,
   output logic        rsp_is_negative,
   output logic        rsp_is_even,
   output logic        rsp_is_square,
   output logic        rsp_is_cube
);
   import icp_pkg::*;

   // lane[0] is the incoming beat, lane[k+1] the register of cell k
   icp_lane_type             lane  [NUM_CELLS+1];
   icp_lane_type             first_lane;
   logic [NUM_CELLS:0]       valid;
   logic [NUM_CELLS:0]       ready;   // ready[k]: cell k can load
   logic [VALUE_W-1:0]       bits;
   logic [VALUE_W-1:0]       mag;

   // magnitude; the most negative value wraps to 2^31 unsigned, which is exact
   assign bits = req_value;
   assign mag  = bits[VALUE_W-1] ? (VALUE_W'(0) - bits) : bits;

   always_comb begin
      first_lane.neg        = bits[VALUE_W-1];
      first_lane.zero       = (bits == '0);
      first_lane.even       = !bits[0];
      first_lane.sq_rem     = mag;
      first_lane.sq_root    = '0;
      first_lane.cb_rem     = mag;
      first_lane.cb_root    = '0;
      first_lane.cb_root_sq = '0;
   end

   assign lane[0]   = first_lane;
   assign valid[0]  = req_valid;
   assign req_stall = !ready[0];
   assign ready[NUM_CELLS] = !rsp_stall;

   // chain of cells, most significant root bit first; the cube root only
   // starts working once the bit index fits its 11-bit root
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      icp_cell #(
         .BIT (NUM_CELLS - 1 - k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid[k]),
         .in_lane    (lane[k]),
         .up_ready   (ready[k]),
         .down_ready (ready[k+1]),
         .out_valid  (valid[k+1]),
         .out_lane   (lane[k+1])
      );
   end

   // the last cell's register is the response register; a zero remainder
   // means the floor root, multiplied back, gives the magnitude exactly
   assign rsp_valid       = valid[NUM_CELLS];
   assign rsp_is_positive = !lane[NUM_CELLS].neg && !lane[NUM_CELLS].zero;
   assign rsp_is_negative = lane[NUM_CELLS].neg;
   assign rsp_is_even     = lane[NUM_CELLS].even;
   assign rsp_is_square   = !lane[NUM_CELLS].neg && (lane[NUM_CELLS].sq_rem == '0);
   assign rsp_is_cube     = (lane[NUM_CELLS].cb_rem == '0);

endmodule
